// ===== design/block_buffer_cache_lru_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the block buffer cache core
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define BLRU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle
`define BLRU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the following cycle
`define BLRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/blru_pkg.sv =====
// ---------------------------------------------------------------------------
// blru_pkg
// Types, codes and sizes shared by the block buffer cache core.
// ---------------------------------------------------------------------------
package blru_pkg;

    localparam int BUF_COUNT = 16;
    localparam int IDX_W     = (BUF_COUNT > 1) ? $clog2(BUF_COUNT) : 1;
    localparam int CNT_W     = $clog2(BUF_COUNT + 1);
    localparam int WR_LIMIT  = 16;
    localparam int RES_W     = 5;

    localparam logic [15:0] DEV_NONE   = 16'hFFFF;
    localparam logic [15:0] MINOR_MASK = 16'h00FF;

    localparam logic [2:0] OP_GET     = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_IODONE  = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_FLUSH   = 3'd4;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_ALLOC    = 3'd1;
    localparam logic [2:0] ST_WAITBUSY = 3'd2;
    localparam logic [2:0] ST_WAITFREE = 3'd3;
    localparam logic [2:0] ST_WRITEOUT = 3'd4;
    localparam logic [2:0] ST_WAKE     = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    typedef struct packed {
        logic error;
        logic wanted;
        logic async;
        logic delwri;
        logic done;
        logic busy;
    } blru_flags_t;

    typedef struct packed {
        logic [15:0] dev;
        logic [15:0] blk;
        blru_flags_t flags;
    } blru_wr_t;

    // free-list chain control
    typedef struct packed {
        logic             rm;
        logic             app;
        logic [IDX_W-1:0] rm_idx;
        logic [IDX_W-1:0] app_idx;
    } blru_qctl_t;

endpackage

// ===== design/blru_buf_cell.sv =====
// ---------------------------------------------------------------------------
// blru_buf_cell
// One buffer: device and block tag, flags and tag comparator.
// ---------------------------------------------------------------------------
module blru_buf_cell import blru_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  blru_wr_t    wr,
    input  logic [15:0] cmp_dev,
    input  logic [15:0] cmp_blk,
    output logic [15:0] tag_dev,
    output logic [15:0] tag_blk,
    output blru_flags_t flags,
    output logic        match
);

    logic [15:0] dev_reg;
    logic [15:0] blk_reg;
    blru_flags_t flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg   <= DEV_NONE;
            blk_reg   <= '0;
            flags_reg <= '0;
        end
        else if (wr_en)
        begin
            dev_reg   <= wr.dev;
            blk_reg   <= wr.blk;
            flags_reg <= wr.flags;
        end
    end

    assign tag_dev = dev_reg;
    assign tag_blk = blk_reg;
    assign flags   = flags_reg;
    assign match   = (dev_reg == cmp_dev) && (blk_reg == cmp_blk);

endmodule

// ===== design/blru_slot.sv =====
// ---------------------------------------------------------------------------
// blru_slot
// One place of the free list; removal shifts the later places down by one.
// ---------------------------------------------------------------------------
module blru_slot import blru_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  blru_qctl_t       ctl,
    input  logic             valid,
    input  logic             load,
    input  logic [IDX_W-1:0] init_idx,
    input  logic             hit_in,
    input  logic [IDX_W-1:0] nbr_idx,
    output logic             hit_out,
    output logic [IDX_W-1:0] idx
);

    logic [IDX_W-1:0] idx_reg;

    // set at and beyond the place of the removed buffer
    assign hit_out = hit_in || (valid && (idx_reg == ctl.rm_idx));
    assign idx     = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= init_idx;
        else if (ctl.rm && hit_out)
            idx_reg <= nbr_idx;
        else if (load)
            idx_reg <= ctl.app_idx;
    end

endmodule

// ===== design/block_buffer_cache_lru_core.sv =====
// ---------------------------------------------------------------------------
// block_buffer_cache_lru_core
// Tag manager of an LRU block buffer cache with delayed write.
// ---------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   word: op, device, block, buffer_index, mark_dirty, io_error,
//                     write_async, flush_all
// m_axis   out  word: status, result_index, result_device, result_block,
//                     data_valid; tlast = last
//
// One item at a time. Get: a lookup, a write-out per dirty victim, allocation.
// Flush: a visit per free-list place, then done. Release: prep, wake, append,
// fin; io_done: prep, wake and append or iowake, fin; write: prep; plus any stall.
// Tags, flags and free list are flip-flops set by reset; no sweep.
// A result waits in the output register; the sequencer stalls until it goes.
// ---------------------------------------------------------------------------
`include "block_buffer_cache_lru_core_defines.svh"

module block_buffer_cache_lru_core import blru_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[2:0], device[18:3], block[34:19], buffer_index[38:35], mark_dirty[39],
    // io_error[40], write_async[41], flush_all[42], zero[47:43]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], result_index[6:3], result_device[22:7], result_block[38:23],
    // data_valid[39]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOKUP, S_ALLOC, S_PREP, S_WAKE, S_APPEND, S_FIN, S_IOWAKE, S_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       op_reg;
    logic [15:0]      dev_reg, blk_reg;
    logic [IDX_W-1:0] cur_reg;
    logic             dirty_reg, err_reg, async_reg, all_reg;
    logic [RES_W-1:0] res_cnt_reg, res_cnt_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg;
    logic             fw_reg, fw_next;
    logic             out_valid_reg;
    logic [39:0]      out_data_reg;
    logic             out_last_reg;

    logic [2:0]  in_op;
    logic [3:0]  in_idx;
    logic        in_range;

    logic [15:0]      c_dev [BUF_COUNT];
    logic [15:0]      c_blk [BUF_COUNT];
    blru_flags_t      c_fl  [BUF_COUNT];
    logic [BUF_COUNT-1:0] c_match;
    logic [IDX_W-1:0] slot_idx [BUF_COUNT];
    logic [BUF_COUNT-1:0] slot_hit;

    logic [IDX_W-1:0] hit_idx, sel;
    logic             hit_any;
    logic [15:0]      s_dev, s_blk;
    blru_flags_t      s_fl, f;
    logic             can_emit, limit, need_wake, fl_cond;
    logic             em, em_buf, em_dv, em_last;
    logic [2:0]       em_st;
    logic [15:0]      em_dev, em_blk;
    logic             wr_en;
    blru_wr_t         wr;
    blru_qctl_t       qctl;

    assign in_op    = s_axis_tdata[2:0];
    assign in_idx   = s_axis_tdata[38:35];
    assign in_range = (32'(in_idx) < BUF_COUNT);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign limit         = (res_cnt_reg >= RES_W'(WR_LIMIT));

    // buffer cells
    for (genvar i = 0; i < BUF_COUNT; i++)
    begin : g_buf
        blru_buf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr_en   (wr_en && (sel == IDX_W'(i))),
            .wr      (wr),
            .cmp_dev (dev_reg),
            .cmp_blk (blk_reg),
            .tag_dev (c_dev[i]),
            .tag_blk (c_blk[i]),
            .flags   (c_fl[i]),
            .match   (c_match[i])
        );
    end

    // free list, head at place 0
    for (genvar k = 0; k < BUF_COUNT; k++)
    begin : g_slot
        logic             hin;
        logic [IDX_W-1:0] nbr;
        if (k == 0)
        begin : g_first
            assign hin = 1'b0;
        end
        else
        begin : g_rest
            assign hin = slot_hit[k-1];
        end
        if (k == BUF_COUNT - 1)
        begin : g_end
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = slot_idx[k+1];
        end
        blru_slot u_slot (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (qctl),
            .valid    (CNT_W'(k) < count_reg),
            .load     (qctl.app && (count_reg == CNT_W'(k))),
            .init_idx (IDX_W'(k)),
            .hit_in   (hin),
            .nbr_idx  (nbr),
            .hit_out  (slot_hit[k]),
            .idx      (slot_idx[k])
        );
    end

    // lowest matching buffer index wins
    always_comb
    begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = BUF_COUNT - 1; i >= 0; i--)
        begin
            if (c_match[i])
            begin
                hit_idx = IDX_W'(i);
                hit_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            S_LOOKUP: sel = hit_idx;
            S_ALLOC:  sel = slot_idx[0];
            S_FLUSH:  sel = slot_idx[pos_reg[IDX_W-1:0]];
            default:  sel = cur_reg;
        endcase
    end

    assign s_dev     = c_dev[sel];
    assign s_blk     = c_blk[sel];
    assign s_fl      = c_fl[sel];
    assign need_wake = s_fl.wanted || fw_reg;
    assign fl_cond   = s_fl.delwri && (all_reg || (dev_reg == DEV_NONE) || (dev_reg == s_dev));

    always_comb
    begin
        f            = s_fl;
        state_next   = state_reg;
        pos_next     = pos_reg;
        fw_next      = fw_reg;
        res_cnt_next = res_cnt_reg;
        em           = 1'b0;
        em_st        = ST_DONE;
        em_buf       = 1'b1;
        em_dev       = s_dev;
        em_blk       = s_blk;
        em_dv        = 1'b0;
        em_last      = 1'b0;
        wr_en        = 1'b0;
        wr.dev       = s_dev;
        wr.blk       = s_blk;
        wr.flags     = s_fl;
        qctl.rm      = 1'b0;
        qctl.app     = 1'b0;
        qctl.rm_idx  = sel;
        qctl.app_idx = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    res_cnt_next = '0;
                    pos_next     = '0;
                    case (in_op)
                        OP_GET:     state_next = S_LOOKUP;
                        OP_FLUSH:   state_next = S_FLUSH;
                        OP_RELEASE,
                        OP_IODONE,
                        OP_WRITE:   state_next = in_range ? S_PREP : S_IDLE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (dev_reg[15] || !hit_any)
                    state_next = S_ALLOC;
                else if (can_emit)
                begin
                    wr_en   = 1'b1;
                    em      = 1'b1;
                    em_last = 1'b1;
                    if (s_fl.busy)
                    begin
                        f.wanted = 1'b1;
                        em_st    = ST_WAITBUSY;
                    end
                    else
                    begin
                        qctl.rm = 1'b1;
                        f.busy  = 1'b1;
                        em_st   = ST_HIT;
                        em_dv   = s_fl.done;
                    end
                    wr.flags   = f;
                    state_next = S_IDLE;
                end
            end
            S_ALLOC:
            begin
                if (can_emit)
                begin
                    em = 1'b1;
                    if ((count_reg == '0) || limit)
                    begin
                        fw_next    = 1'b1;
                        em_st      = ST_WAITFREE;
                        em_buf     = 1'b0;
                        em_last    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        qctl.rm = 1'b1;
                        wr_en   = 1'b1;
                        if (s_fl.delwri)
                        begin
                            // dirty victim: write back and try the next head
                            f.busy   = 1'b1;
                            f.async  = 1'b1;
                            f.done   = 1'b0;
                            f.error  = 1'b0;
                            f.delwri = 1'b0;
                            em_st    = ST_WRITEOUT;
                        end
                        else
                        begin
                            f          = '0;
                            f.busy     = 1'b1;
                            wr.dev     = dev_reg;
                            wr.blk     = blk_reg;
                            em_dev     = dev_reg;
                            em_blk     = blk_reg;
                            em_st      = ST_ALLOC;
                            em_last    = 1'b1;
                            state_next = S_IDLE;
                        end
                        wr.flags = f;
                    end
                end
            end
            S_PREP:
            begin
                case (op_reg)
                    OP_RELEASE:
                    begin
                        if (dirty_reg)
                        begin
                            f.delwri = 1'b1;
                            f.done   = 1'b1;
                        end
                        if (err_reg)
                            f.error = 1'b1;
                        wr_en      = 1'b1;
                        wr.flags   = f;
                        state_next = S_WAKE;
                    end
                    OP_IODONE:
                    begin
                        f.done = 1'b1;
                        if (err_reg)
                            f.error = 1'b1;
                        if (s_fl.async)
                            state_next = S_WAKE;
                        else
                        begin
                            f.wanted   = 1'b0;
                            state_next = S_IOWAKE;
                        end
                        wr_en    = 1'b1;
                        wr.flags = f;
                    end
                    OP_WRITE:
                    begin
                        if (can_emit)
                        begin
                            if (async_reg)
                                f.async = 1'b1;
                            qctl.rm    = !s_fl.busy;
                            f.busy     = 1'b1;
                            f.done     = 1'b0;
                            f.error    = 1'b0;
                            f.delwri   = 1'b0;
                            wr_en      = 1'b1;
                            wr.flags   = f;
                            em         = 1'b1;
                            em_st      = ST_WRITEOUT;
                            em_last    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_WAKE:
            begin
                if (!need_wake || can_emit)
                begin
                    em       = need_wake;
                    em_st    = ST_WAKE;
                    fw_next  = 1'b0;
                    wr_en    = 1'b1;
                    if (s_fl.error)
                        wr.dev = s_dev | MINOR_MASK;
                    f.wanted = 1'b0;
                    f.busy   = 1'b0;
                    f.async  = 1'b0;
                    wr.flags = f;
                    qctl.rm  = !s_fl.busy;
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                qctl.app   = 1'b1;
                state_next = S_FIN;
            end
            S_IOWAKE:
            begin
                if (can_emit)
                begin
                    em         = 1'b1;
                    em_st      = ST_WAKE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (can_emit)
                begin
                    em         = 1'b1;
                    em_st      = ST_DONE;
                    em_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if ((pos_reg >= count_reg) || (fl_cond && limit))
                begin
                    if (can_emit)
                    begin
                        em         = 1'b1;
                        em_st      = ST_DONE;
                        em_buf     = 1'b0;
                        em_last    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!fl_cond)
                    pos_next = pos_reg + 1'b1;
                else if (can_emit)
                begin
                    // removal pulls the next buffer into this place
                    f.busy   = 1'b1;
                    f.async  = 1'b1;
                    f.done   = 1'b0;
                    f.error  = 1'b0;
                    f.delwri = 1'b0;
                    wr_en    = 1'b1;
                    wr.flags = f;
                    qctl.rm  = 1'b1;
                    em       = 1'b1;
                    em_st    = ST_WRITEOUT;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (em)
            res_cnt_next = res_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_cnt_reg   <= '0;
            pos_reg       <= '0;
            count_reg     <= CNT_W'(BUF_COUNT);
            fw_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_cnt_reg <= res_cnt_next;
            pos_reg     <= pos_next;
            fw_reg      <= fw_next;
            if (qctl.rm)
                count_reg <= count_reg - 1'b1;
            else if (qctl.app)
                count_reg <= count_reg + 1'b1;
            if (em)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            op_reg    <= in_op;
            dev_reg   <= s_axis_tdata[18:3];
            blk_reg   <= s_axis_tdata[34:19];
            cur_reg   <= IDX_W'(in_idx);
            dirty_reg <= s_axis_tdata[39];
            err_reg   <= s_axis_tdata[40];
            async_reg <= s_axis_tdata[41];
            all_reg   <= s_axis_tdata[42];
        end
        if (em)
        begin
            out_data_reg <= {em_dv,
                             em_buf ? em_blk : 16'h0000,
                             em_buf ? em_dev : 16'h0000,
                             em_buf ? 4'(sel) : 4'h0,
                             em_st};
            out_last_reg <= em_last;
        end
    end

    `BLRU_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(BUF_COUNT), "free count overflow")
    `BLRU_ASSERT_NEXT(a_accept_clears, s_axis_tvalid && s_axis_tready, res_cnt_reg == '0, "result count not cleared")
    `BLRU_ASSERT_IMP(a_rm_app_excl, qctl.rm, !qctl.app, "free list removal and append together")
    `BLRU_ASSERT_NEXT(a_stall_hold, out_valid_reg && !m_axis_tready, out_valid_reg && $stable(out_data_reg), "stalled word changed")

endmodule

// ===== tb/tb_block_buffer_cache_lru_core.sv =====
// ---------------------------------------------------------------------------
// Buffer cache tag manager testbench
// Drives get, release, io_done, write and flush words through the stream
// ports, models tags, flags and the free list, and checks every result word.
// ---------------------------------------------------------------------------
module tb_block_buffer_cache_lru_core import blru_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = BUF_COUNT;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  index;
        logic [15:0] dev;
        logic [15:0] blk;
        logic        dvalid;
        logic        last;
    } result_t;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] dev;
        logic [15:0] blk;
        logic [3:0]  idx;
        logic        dirty;
        logic        err;
        logic        async_wr;
        logic        all;
        logic        chk;
        logic [2:0]  st0;
    } stim_t;

    typedef bit  bool_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    block_buffer_cache_lru_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow cache state
    logic [15:0] sh_dev [NB];
    logic [15:0] sh_blk [NB];
    blru_flags_t sh_fl  [NB];
    int          sh_nxt [NB];
    int          sh_prv [NB];
    int          sh_head, sh_tail;
    logic        sh_free_wanted;

    result_t     exp_words[$];
    result_t     step_words[$];
    int          errors;
    int          n_words;
    bool_t       quiet_tx, quiet_rx;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report(input string what, input result_t got, input result_t want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic void push_word(input logic [2:0] st, input int b, input logic v);
        result_t r;
        r = '0;
        r.status = st;
        if (b < NB)
        begin
            r.index = b[3:0];
            r.dev = sh_dev[b];
            r.blk = sh_blk[b];
        end
        r.dvalid = v;
        step_words.push_back(r);
    endfunction

    function automatic void list_unlink(input int b);
        int p, n;
        p = sh_prv[b];
        n = sh_nxt[b];
        if (p >= NB) sh_head = n; else sh_nxt[p] = n;
        if (n >= NB) sh_tail = p; else sh_prv[n] = p;
        sh_nxt[b] = NB;
        sh_prv[b] = NB;
    endfunction

    function automatic void list_append(input int b);
        sh_prv[b] = sh_tail;
        sh_nxt[b] = NB;
        if (sh_tail >= NB) sh_head = b; else sh_nxt[sh_tail] = b;
        sh_tail = b;
    endfunction

    function automatic void take_buf(input int b);
        if (!sh_fl[b].busy) list_unlink(b);
        sh_fl[b].busy = 1'b1;
    endfunction

    function automatic void begin_write(input int b);
        sh_fl[b].done = 0;
        sh_fl[b].error = 0;
        sh_fl[b].delwri = 0;
        push_word(ST_WRITEOUT, b, 0);
    endfunction

    function automatic void free_buf(input int b, input logic err);
        logic was_free;
        was_free = !sh_fl[b].busy;
        if (err) sh_fl[b].error = 1;
        if (sh_fl[b].wanted || sh_free_wanted) push_word(ST_WAKE, b, 0);
        sh_free_wanted = 0;
        if (sh_fl[b].error) sh_dev[b] = sh_dev[b] | MINOR_MASK;
        sh_fl[b].wanted = 0;
        sh_fl[b].busy = 0;
        sh_fl[b].async = 0;
        if (was_free) list_unlink(b);
        list_append(b);
    endfunction

    function automatic void cache_reset();
        for (int i = 0; i < NB; i++)
        begin
            sh_dev[i] = DEV_NONE;
            sh_blk[i] = '0;
            sh_fl[i] = '0;
            sh_nxt[i] = i + 1;
            sh_prv[i] = (i == 0) ? NB : i - 1;
        end
        sh_head = 0;
        sh_tail = NB - 1;
        sh_free_wanted = 0;
    endfunction

    // works out the result words of one input word into step_words
    function automatic void cache_step(input stim_t s);
        int h, i, n;
        logic found;
        step_words.delete();
        if (s.op > OP_FLUSH) return;
        case (s.op)
            OP_GET:
            begin
                found = 0;
                if (!s.dev[15])
                    for (i = 0; i < NB && !found; i++)
                        if (sh_dev[i] == s.dev && sh_blk[i] == s.blk)
                        begin
                            found = 1;
                            if (sh_fl[i].busy)
                            begin
                                sh_fl[i].wanted = 1;
                                push_word(ST_WAITBUSY, i, 0);
                            end
                            else
                            begin
                                take_buf(i);
                                push_word(ST_HIT, i, sh_fl[i].done);
                            end
                        end
                while (!found)
                begin
                    h = sh_head;
                    if (h >= NB || step_words.size() >= WR_LIMIT)
                    begin
                        sh_free_wanted = 1;
                        push_word(ST_WAITFREE, NB, 0);
                        found = 1;
                    end
                    else
                    begin
                        take_buf(h);
                        if (sh_fl[h].delwri)
                        begin
                            sh_fl[h].async = 1;
                            begin_write(h);
                        end
                        else
                        begin
                            sh_fl[h] = '0;
                            sh_fl[h].busy = 1;
                            sh_dev[h] = s.dev;
                            sh_blk[h] = s.blk;
                            push_word(ST_ALLOC, h, 0);
                            found = 1;
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                if (s.dirty)
                begin
                    sh_fl[s.idx].delwri = 1;
                    sh_fl[s.idx].done = 1;
                end
                free_buf(s.idx, s.err);
                push_word(ST_DONE, s.idx, 0);
            end
            OP_IODONE:
            begin
                sh_fl[s.idx].done = 1;
                if (s.err) sh_fl[s.idx].error = 1;
                if (sh_fl[s.idx].async)
                    free_buf(s.idx, 0);
                else
                begin
                    sh_fl[s.idx].wanted = 0;
                    push_word(ST_WAKE, s.idx, 0);
                end
                push_word(ST_DONE, s.idx, 0);
            end
            OP_WRITE:
            begin
                if (s.async_wr) sh_fl[s.idx].async = 1;
                take_buf(s.idx);
                begin_write(s.idx);
            end
            default:
            begin
                i = sh_head;
                while (i < NB)
                begin
                    n = sh_nxt[i];
                    if (sh_fl[i].delwri && (s.all || s.dev == DEV_NONE || s.dev == sh_dev[i]))
                    begin
                        if (step_words.size() >= WR_LIMIT) break;
                        sh_fl[i].async = 1;
                        take_buf(i);
                        begin_write(i);
                    end
                    i = n;
                end
                push_word(ST_DONE, NB, 0);
            end
        endcase
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1;
    endfunction

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[22:7],
                   m_axis_tdata[38:23], m_axis_tdata[39], m_axis_tlast};
            n_words++;
            if (exp_words.size() == 0)
                report("unexpected word", got, '0);
            else
            begin
                want = exp_words.pop_front();
                if (got.status != want.status) report("status", got, want);
                else if (got.index != want.index) report("index", got, want);
                else if (got.dev != want.dev) report("device", got, want);
                else if (got.blk != want.blk) report("block", got, want);
                else if (got.dvalid != want.dvalid) report("data_valid", got, want);
                else if (got.last != want.last) report("last", got, want);
            end
        end
        m_axis_tready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 6);
    end

    function automatic stim_t mk(input logic [2:0] op, input logic [15:0] dev,
                                 input logic [15:0] blk, input logic [3:0] idx,
                                 input logic d, input logic e, input logic a,
                                 input logic all, input logic chk = 0,
                                 input logic [2:0] st0 = 0);
        stim_t s;
        s.op = op; s.dev = dev; s.blk = blk; s.idx = idx; s.dirty = d; s.err = e;
        s.async_wr = a; s.all = all; s.chk = chk; s.st0 = st0;
        return s;
    endfunction

    task automatic send(input stim_t s);
        result_t r;
        if (!quiet_tx)
            while ($urandom_range(99) < 6)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, s.all, s.async_wr, s.err, s.dirty, s.idx, s.blk, s.dev, s.op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        cache_step(s);
        if (s.chk && step_words.size() > 0 && step_words[0].status != s.st0)
        begin
            r = '0;
            r.status = s.st0;
            report("table row", step_words[0], r);
        end
        foreach (step_words[k]) exp_words.push_back(step_words[k]);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (exp_words.size() != 0) @(posedge clk);
    endtask

    // random word biased towards live buffers and a small tag space
    function automatic stim_t rnd_word();
        stim_t s;
        int sel;
        s = mk(3'($urandom_range(4)),
               {8'($urandom_range(2)), 8'd0} | 16'($urandom_range(3)),
               16'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)),
               ($urandom_range(9) == 0), 1'($urandom_range(1)), ($urandom_range(3) == 0));
        sel = $urandom_range(99);
        if (sel < 3) s.op = 3'($urandom_range(7, 5));
        else if (sel < 6) s.dev = 16'($urandom);
        else if (sel < 9) s.blk = 16'($urandom);
        else if (sel < 12) s.dev = 16'h8000 | 16'($urandom);
        // release and io_done only on busy buffers, mostly
        if ((s.op == OP_RELEASE || s.op == OP_IODONE) && $urandom_range(9) != 0)
            for (int i = 0; i < NB; i++)
                if (sh_fl[(s.idx + i) % NB].busy)
                begin
                    s.idx = 4'((s.idx + i) % NB);
                    break;
                end
        return s;
    endfunction

    initial
    begin
        stim_t dir_tab[$];
        errors = 0;
        n_words = 0;
        quiet_tx = 0;
        quiet_rx = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        cache_reset();
        dir_tab = '{
            mk(OP_GET, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 1, ST_ALLOC),
            mk(OP_GET, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 1, ST_WAITBUSY),
            mk(OP_GET, 16'h7FFF, 16'hFFFF, 0, 0, 0, 0, 0, 1, ST_ALLOC),
            mk(OP_GET, 16'hFFFF, 16'h0000, 0, 0, 0, 0, 0, 1, ST_ALLOC),
            mk(OP_GET, 16'hFFFF, 16'h0000, 0, 0, 0, 0, 0, 1, ST_ALLOC),
            mk(OP_RELEASE, 0, 0, 0, 1, 0, 0, 0, 1, ST_WAKE),
            mk(OP_RELEASE, 0, 0, 1, 0, 1, 0, 0, 1, ST_DONE),
            mk(OP_GET, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 1, ST_HIT),
            mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 1, ST_WRITEOUT),
            mk(OP_IODONE, 0, 0, 0, 0, 0, 0, 0, 1, ST_WAKE),
            mk(OP_RELEASE, 0, 0, 0, 1, 0, 0, 0),
            mk(OP_WRITE, 0, 0, 15, 0, 0, 1, 0, 1, ST_WRITEOUT),
            mk(OP_IODONE, 0, 0, 15, 0, 1, 0, 0),
            mk(OP_FLUSH, 16'hFFFF, 0, 0, 0, 0, 0, 0),
            mk(OP_IODONE, 0, 0, 0, 0, 0, 0, 0),
            mk(OP_RELEASE, 0, 0, 2, 1, 0, 0, 0),
            mk(OP_RELEASE, 0, 0, 3, 1, 0, 0, 0),
            mk(OP_FLUSH, 16'h1234, 0, 0, 0, 0, 0, 1),
            mk(OP_FLUSH, 16'h1234, 0, 0, 0, 0, 0, 0, 1, ST_DONE),
            mk(OP_GET, 16'h8000, 16'h5555, 0, 0, 0, 0, 0),
            mk(3'd5, 16'hFFFF, 16'hFFFF, 15, 1, 1, 1, 1),
            mk(3'd7, 0, 0, 0, 0, 0, 0, 0),
            mk(OP_GET, 16'h00AA, 16'hAAAA, 0, 0, 0, 0, 0)
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[k]) send(dir_tab[k]);
        // fill the cache with dirty buffers so a get must write many out
        drain();
        for (int i = 0; i < NB; i++)
            if (!sh_fl[i].busy)
                send(mk(OP_WRITE, 0, 0, 4'(i), 0, 0, 1, 0));
        for (int i = 0; i < NB; i++) send(mk(OP_RELEASE, 0, 0, 4'(i), 1, 0, 0, 0));
        send(mk(OP_GET, 16'h0101, 16'h0001, 0, 0, 0, 0, 0));
        for (int k = 0; k < 125; k++)
        begin
            if (k == 40) drain();
            quiet_tx = (k >= 70 && k < 110);
            quiet_rx = quiet_tx;
            send(rnd_word());
        end
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && exp_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
